[src/segpit_pkg.sv]
// Shared types and constants for the segment pair intersection test.
// Used by every module of the block; depends on nothing.
package segpit_pkg;

    localparam int FIELD_W        = 32;
    localparam int COORD_BITS_DEF = 32;
    localparam int NUM_PTS        = 4;
    localparam int NUM_ORIENT     = 4;
    localparam int NUM_DIFF       = 4 * NUM_ORIENT;
    localparam int NUM_PROD       = 2 * NUM_ORIENT;

    // Orientation k is (b - a) x (c - a) with a, b, c taken from these point indexes:
    // (p0,p1,p2), (p0,p1,p3), (p2,p3,p0), (p2,p3,p1)
    localparam logic [1:0] ORIENT_A [NUM_ORIENT] = '{2'd0, 2'd0, 2'd2, 2'd2};
    localparam logic [1:0] ORIENT_B [NUM_ORIENT] = '{2'd1, 2'd1, 2'd3, 2'd3};
    localparam logic [1:0] ORIENT_C [NUM_ORIENT] = '{2'd2, 2'd3, 2'd0, 2'd1};

    // Point equality and on-segment flags, formed in the first stage
    typedef struct packed {
        logic same_01;
        logic same_23;
        logic same_12;
        logic on2_01;
        logic on3_01;
        logic on0_23;
        logic on1_23;
    } seg_flags_t;

    // Sign of each orientation value: positive, or exactly zero
    typedef struct packed {
        logic [NUM_ORIENT-1:0] pos;
        logic [NUM_ORIENT-1:0] zero;
    } orient_flags_t;

endpackage

[src/segpit_prep.sv]
// First stage: trims coordinates, forms the cross product operand differences
// and the point equality / betweenness flags. Depends on segpit_pkg.
module segpit_prep
    import segpit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [FIELD_W-1:0]           coord    [2*NUM_PTS],
    output logic signed [COORD_BITS:0]   diff_reg [NUM_DIFF],
    output seg_flags_t                   flags_reg
);

    localparam int CW = COORD_BITS;
    localparam int DW = COORD_BITS + 1;

    logic signed [CW-1:0] px [NUM_PTS];
    logic signed [CW-1:0] py [NUM_PTS];
    logic signed [DW-1:0] ex [NUM_PTS];
    logic signed [DW-1:0] ey [NUM_PTS];
    logic signed [DW-1:0] diff_next [NUM_DIFF];
    seg_flags_t           flags_next;

    function automatic logic betw(input logic signed [CW-1:0] a,
                                  input logic signed [CW-1:0] x,
                                  input logic signed [CW-1:0] b);
        return (x == a) || (x == b) || ((a > x) == (x > b));
    endfunction

    always_comb begin
        for (int i = 0; i < NUM_PTS; i++) begin
            px[i] = coord[2*i][CW-1:0];
            py[i] = coord[2*i+1][CW-1:0];
            ex[i] = {px[i][CW-1], px[i]};
            ey[i] = {py[i][CW-1], py[i]};
        end
        for (int k = 0; k < NUM_ORIENT; k++) begin
            diff_next[4*k]   = ex[ORIENT_B[k]] - ex[ORIENT_A[k]];
            diff_next[4*k+1] = ey[ORIENT_C[k]] - ey[ORIENT_A[k]];
            diff_next[4*k+2] = ex[ORIENT_C[k]] - ex[ORIENT_A[k]];
            diff_next[4*k+3] = ey[ORIENT_B[k]] - ey[ORIENT_A[k]];
        end
        flags_next.same_01 = (px[0] == px[1]) && (py[0] == py[1]);
        flags_next.same_23 = (px[2] == px[3]) && (py[2] == py[3]);
        flags_next.same_12 = (px[1] == px[2]) && (py[1] == py[2]);
        flags_next.on2_01  = betw(px[0], px[2], px[1]) && betw(py[0], py[2], py[1]);
        flags_next.on3_01  = betw(px[0], px[3], px[1]) && betw(py[0], py[3], py[1]);
        flags_next.on0_23  = betw(px[2], px[0], px[3]) && betw(py[2], py[0], py[3]);
        flags_next.on1_23  = betw(px[2], px[1], px[3]) && betw(py[2], py[1], py[3]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg  <= diff_next;
            flags_reg <= flags_next;
        end
    end

endmodule

[src/segpit_mul.sv]
// Second stage: the eight signed products of the four cross products.
// Depends on segpit_pkg.
module segpit_mul
    import segpit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [COORD_BITS:0]        diff      [NUM_DIFF],
    input  seg_flags_t                        flags,
    output logic signed [2*COORD_BITS+1:0]    prod_reg  [NUM_PROD],
    output seg_flags_t                        flags_reg
);

    localparam int PW = 2 * (COORD_BITS + 1);

    logic signed [PW-1:0] prod_next [NUM_PROD];

    always_comb begin
        for (int k = 0; k < NUM_ORIENT; k++) begin
            prod_next[2*k]   = diff[4*k]   * diff[4*k+1];
            prod_next[2*k+1] = diff[4*k+2] * diff[4*k+3];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= prod_next;
            flags_reg <= flags;
        end
    end

endmodule

[src/segpit_orient.sv]
// Third stage: subtracts product pairs and keeps the sign and zero flags of
// each orientation value. Depends on segpit_pkg.
module segpit_orient
    import segpit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [2*COORD_BITS+1:0]    prod       [NUM_PROD],
    input  seg_flags_t                        flags,
    output orient_flags_t                     oflags_reg,
    output seg_flags_t                        flags_reg
);

    localparam int PW = 2 * (COORD_BITS + 1);

    logic signed [PW:0] od [NUM_ORIENT];
    orient_flags_t      oflags_next;

    always_comb begin
        for (int k = 0; k < NUM_ORIENT; k++) begin
            od[k]               = prod[2*k] - prod[2*k+1];
            oflags_next.zero[k] = (od[k] == '0);
            oflags_next.pos[k]  = !od[k][PW] && (od[k] != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            oflags_reg <= oflags_next;
            flags_reg  <= flags;
        end
    end

endmodule

[src/segment_pair_intersection_test_top.sv]
// Segment pair intersection test, top level. Uses segpit_pkg and the stage
// modules segpit_prep, segpit_mul and segpit_orient.
// Pipeline: four register stages (prep, multiply, orientation sign, decision), taken in
// turn. Throughput: one item per cycle while the output is not stalled by m_ready;
// a stage advances when empty or when the next one does.
// Reset (aresetn low at a clock edge) clears all stage valid bits.
module segment_pair_intersection_test_top
    import segpit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FIELD_W-1:0] s_first_start_x,
    input  logic [FIELD_W-1:0] s_first_start_y,
    input  logic [FIELD_W-1:0] s_first_end_x,
    input  logic [FIELD_W-1:0] s_first_end_y,
    input  logic [FIELD_W-1:0] s_second_start_x,
    input  logic [FIELD_W-1:0] s_second_start_y,
    input  logic [FIELD_W-1:0] s_second_end_x,
    input  logic [FIELD_W-1:0] s_second_end_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_segments_touch
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic [FIELD_W-1:0]   coord [2*NUM_PTS];
    logic signed [DW-1:0] s1_diff [NUM_DIFF];
    logic signed [PW-1:0] s2_prod [NUM_PROD];
    seg_flags_t           s1_flags, s2_flags, s3_flags;
    orient_flags_t        s3_oflags;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;
    logic hit_next, touch_reg;
    logic side_same, hit01, hit23;

    // A stage moves when it is empty or its successor moves
    assign adv4    = !v4_reg || m_ready;
    assign adv3    = !v3_reg || adv4;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    always_comb begin
        coord[0] = s_first_start_x;
        coord[1] = s_first_start_y;
        coord[2] = s_first_end_x;
        coord[3] = s_first_end_y;
        coord[4] = s_second_start_x;
        coord[5] = s_second_start_y;
        coord[6] = s_second_end_x;
        coord[7] = s_second_end_y;
    end

    segpit_prep #(.COORD_BITS(COORD_BITS)) u_prep (
        .aclk      (aclk),
        .en        (adv1),
        .coord     (coord),
        .diff_reg  (s1_diff),
        .flags_reg (s1_flags)
    );

    segpit_mul #(.COORD_BITS(COORD_BITS)) u_mul (
        .aclk      (aclk),
        .en        (adv2),
        .diff      (s1_diff),
        .flags     (s1_flags),
        .prod_reg  (s2_prod),
        .flags_reg (s2_flags)
    );

    segpit_orient #(.COORD_BITS(COORD_BITS)) u_orient (
        .aclk       (aclk),
        .en         (adv3),
        .prod       (s2_prod),
        .flags      (s2_flags),
        .oflags_reg (s3_oflags),
        .flags_reg  (s3_flags)
    );

    // Decision: collinear on-segment touch first, then the side test
    always_comb begin
        hit01 = !s3_flags.same_01 &&
                ((s3_oflags.zero[0] && s3_flags.on2_01) ||
                 (s3_oflags.zero[1] && s3_flags.on3_01));
        hit23 = !s3_flags.same_23 &&
                ((s3_oflags.zero[2] && s3_flags.on0_23) ||
                 (s3_oflags.zero[3] && s3_flags.on1_23));
        side_same = (s3_oflags.pos[0] == s3_oflags.pos[1]) ||
                    (s3_oflags.pos[2] == s3_oflags.pos[3]);
        hit_next  = hit01 || hit23 || (side_same ? s3_flags.same_12 : 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            touch_reg <= hit_next;
        end
    end

    assign m_valid          = v4_reg;
    assign m_segments_touch = touch_reg;

`ifndef SYNTHESIS
    // Full pipeline with a stalled output takes no new item
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && v3_reg && v4_reg && !m_ready) |-> !s_ready)
        else $error("input accepted while pipeline full and stalled");

    // An accepted item lands in the first stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted item lost at first stage");

    // A held item in the orientation stage is not dropped
    a_hold_s3: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !adv3) |=> (v3_reg && $stable(s3_oflags)))
        else $error("stalled orientation stage changed");

    // An orientation value is never both positive and zero
    a_orient_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> ((s3_oflags.pos & s3_oflags.zero) == '0))
        else $error("orientation flagged positive and zero");
`endif

endmodule
